// File: rtl/core/palette_tint_shade_blend_top_defines.svh
// Assertion macros for the checker file of the palette blender.
// No dependencies; include by bare file name.
`ifndef PALETTE_TINT_SHADE_BLEND_TOP_DEFINES_SVH
`define PALETTE_TINT_SHADE_BLEND_TOP_DEFINES_SVH

// Concurrent assertion on the rising clock edge, disabled during reset.
`define PTSB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Concurrent assertion on the rising clock edge that also holds during reset.
`define PTSB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: rtl/core/ptsb_pkg.sv
// Package of the palette tint/shade blender: types, constants, blend function.
// No dependencies.
`default_nettype none

package ptsb_pkg;

  localparam int unsigned CompW = 6;

  localparam logic [7:0] START_HIGH  = 8'h70;
  localparam logic [7:0] START_LOW   = 8'h10;
  localparam logic [6:0] FULL_WEIGHT = 7'h40;
  localparam logic [7:0] SHADE_MIN   = 8'h0f;

  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_HIGH = 2'd1,
    MODE_LOW  = 2'd2
  } blend_mode_e;

  typedef enum logic [2:0] {
    REG_BLEND_MODE  = 3'd0,
    REG_TINT_WEIGHT = 3'd1,
    REG_TINT_COLOR  = 3'd2,
    REG_BAND_COLOR  = 3'd3,
    REG_BAND_WEIGHT = 3'd4,
    REG_SHADE_COLOR = 3'd5,
    REG_SHADE_LEVEL = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [CompW-1:0] red;
    logic [CompW-1:0] green;
    logic [CompW-1:0] blue;
  } rgb_t;

  // One palette entry as it travels down the pipeline.
  typedef struct packed {
    logic [7:0] idx;
    rgb_t       rgb;
    logic       active;
  } item_t;

  // Controls of one blend step.
  typedef struct packed {
    logic             en;
    logic [CompW-1:0] k;
    rgb_t             target;
  } step_ctrl_t;

  // Moves one component toward its target: src +- (((|d| - 1) * k) >> 6).
  function automatic logic [CompW-1:0] lerp_comp(input logic [CompW-1:0] src,
                                                 input logic [CompW-1:0] tgt,
                                                 input logic [CompW-1:0] k);
    logic [CompW-1:0]   diff;
    logic [2*CompW-1:0] prod;
    logic [CompW-1:0]   mag;
    diff = (tgt > src) ? (tgt - src - 1'b1) : (src - tgt - 1'b1);
    prod = {{CompW{1'b0}}, diff} * {{CompW{1'b0}}, k};
    mag  = prod[2*CompW-1:CompW];
    if (tgt > src) begin
      return src + mag;
    end else if (tgt < src) begin
      return src - mag;
    end
    return src;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/ptsb_step.sv
// One registered blend step of the palette blender pipeline.
// Depends on ptsb_pkg.
`default_nettype none

module ptsb_step (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                valid_i,
  input  wire ptsb_pkg::item_t     item_i,
  input  wire ptsb_pkg::step_ctrl_t ctrl_i,
  output logic                     valid_o,
  output ptsb_pkg::item_t          item_o
);

  logic            valid_q;
  ptsb_pkg::item_t item_d, item_q;

  always_comb begin
    item_d = item_i;
    if (item_i.active && ctrl_i.en) begin
      item_d.rgb.red   = ptsb_pkg::lerp_comp(item_i.rgb.red,   ctrl_i.target.red,   ctrl_i.k);
      item_d.rgb.green = ptsb_pkg::lerp_comp(item_i.rgb.green, ctrl_i.target.green, ctrl_i.k);
      item_d.rgb.blue  = ptsb_pkg::lerp_comp(item_i.rgb.blue,  ctrl_i.target.blue,  ctrl_i.k);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

// File: rtl/core/palette_tint_shade_blend_top.sv
// Top level of the palette tint/shade blender: config registers, input stage
// and three blend steps. Depends on ptsb_pkg and ptsb_step.
//
// Usage: one palette entry (index plus 6-bit red, green, blue) is taken as a
// request at each rising edge where start is high and busy is low. busy is
// always low, so a new request can be issued in every cycle.
// The path runs through the input register, then the tint, band and shade
// steps, each one register stage holding one 6x6 multiply per component.
// The result shows on the out_* ports for exactly one cycle with out_valid_o
// high, from the register of the shade step. Throughput is one entry per cycle.
// The receiver cannot stall, so the pipeline never holds.
// Entries below the start index of the current mode (112 or 16), and all
// entries in mode off, pass through with was_blended_o low.
// Configuration registers are written through cfg_valid_i/cfg_ready_o with a
// register index and data; cfg_ready_o is always high. Writes are expected
// only while the pipeline is empty. Indexes past the shade level are ignored.
// Reset clears the pipeline valid bits and loads the register defaults:
// mode 1, both weights 64, shade level 64, all target colors black.
`default_nettype none

module palette_tint_shade_blend_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [7:0]  entry_index_i,
  input  wire logic [5:0]  in_red_i,
  input  wire logic [5:0]  in_green_i,
  input  wire logic [5:0]  in_blue_i,
  output logic             out_valid_o,
  output logic [7:0]       out_index_o,
  output logic [5:0]       out_red_o,
  output logic [5:0]       out_green_o,
  output logic [5:0]       out_blue_o,
  output logic             was_blended_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [17:0] cfg_data_i
);

  // Configuration registers.
  logic [1:0]  blend_mode_q;
  logic [6:0]  tint_weight_q;
  logic [17:0] tint_color_q;
  logic [17:0] band_color_q;
  logic [6:0]  band_weight_q;
  logic [17:0] shade_color_q;
  logic [7:0]  shade_level_q;

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blend_mode_q  <= ptsb_pkg::MODE_HIGH;
      tint_weight_q <= ptsb_pkg::FULL_WEIGHT;
      tint_color_q  <= '0;
      band_color_q  <= '0;
      band_weight_q <= ptsb_pkg::FULL_WEIGHT;
      shade_color_q <= '0;
      shade_level_q <= 8'(ptsb_pkg::FULL_WEIGHT);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        ptsb_pkg::REG_BLEND_MODE:  blend_mode_q  <= cfg_data_i[1:0];
        ptsb_pkg::REG_TINT_WEIGHT: tint_weight_q <= cfg_data_i[6:0];
        ptsb_pkg::REG_TINT_COLOR:  tint_color_q  <= cfg_data_i;
        ptsb_pkg::REG_BAND_COLOR:  band_color_q  <= cfg_data_i;
        ptsb_pkg::REG_BAND_WEIGHT: band_weight_q <= cfg_data_i[6:0];
        ptsb_pkg::REG_SHADE_COLOR: shade_color_q <= cfg_data_i;
        ptsb_pkg::REG_SHADE_LEVEL: shade_level_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Input stage: the mode and start index decide whether the entry blends.
  logic            in_active;
  logic            s0_valid_q;
  ptsb_pkg::item_t s0_item_d, s0_item_q;

  always_comb begin
    unique case (blend_mode_q)
      ptsb_pkg::MODE_HIGH: in_active = (entry_index_i >= ptsb_pkg::START_HIGH);
      ptsb_pkg::MODE_LOW:  in_active = (entry_index_i >= ptsb_pkg::START_LOW);
      default:             in_active = 1'b0;
    endcase
    s0_item_d.idx       = entry_index_i;
    s0_item_d.rgb.red   = in_red_i;
    s0_item_d.rgb.green = in_green_i;
    s0_item_d.rgb.blue  = in_blue_i;
    s0_item_d.active    = in_active;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else begin
      s0_valid_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_item_q <= s0_item_d;
  end

  // Step controls. A weight blends only when it lies in 1..63; k is 64 minus
  // the weight. The shade level is clamped from below to 15, and any level
  // of 64 or more makes the shade step pass through.
  ptsb_pkg::step_ctrl_t tint_ctrl, band_ctrl, shade_ctrl;
  logic [5:0]           shade_lvl;

  always_comb begin
    tint_ctrl.en     = (tint_weight_q != '0) && (tint_weight_q < ptsb_pkg::FULL_WEIGHT);
    tint_ctrl.k      = 6'(ptsb_pkg::FULL_WEIGHT - tint_weight_q);
    tint_ctrl.target = tint_color_q;

    band_ctrl.en     = (band_weight_q != '0) && (band_weight_q < ptsb_pkg::FULL_WEIGHT);
    band_ctrl.k      = 6'(ptsb_pkg::FULL_WEIGHT - band_weight_q);
    band_ctrl.target = band_color_q;

    shade_lvl = (shade_level_q < ptsb_pkg::SHADE_MIN) ? ptsb_pkg::SHADE_MIN[5:0]
                                                      : shade_level_q[5:0];
    shade_ctrl.en     = (shade_level_q < 8'(ptsb_pkg::FULL_WEIGHT));
    shade_ctrl.k      = 6'(ptsb_pkg::FULL_WEIGHT - {1'b0, shade_lvl});
    shade_ctrl.target = shade_color_q;
  end

  // Three cascaded blend stages.
  logic            s1_valid, s2_valid, s3_valid;
  ptsb_pkg::item_t s1_item, s2_item, s3_item;

  ptsb_step u_tint (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s0_valid_q),
    .item_i  (s0_item_q),
    .ctrl_i  (tint_ctrl),
    .valid_o (s1_valid),
    .item_o  (s1_item)
  );

  ptsb_step u_band (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .item_i  (s1_item),
    .ctrl_i  (band_ctrl),
    .valid_o (s2_valid),
    .item_o  (s2_item)
  );

  ptsb_step u_shade (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid),
    .item_i  (s2_item),
    .ctrl_i  (shade_ctrl),
    .valid_o (s3_valid),
    .item_o  (s3_item)
  );

  // The last step's register is the result register.
  assign out_valid_o   = s3_valid;
  assign out_index_o   = s3_item.idx;
  assign out_red_o     = s3_item.rgb.red;
  assign out_green_o   = s3_item.rgb.green;
  assign out_blue_o    = s3_item.rgb.blue;
  assign was_blended_o = s3_item.active;

endmodule

`default_nettype wire

// File: rtl/core/ptsb_checker.sv
// Port-level checker of the palette blender and its bind to the top level.
// Depends on palette_tint_shade_blend_top_defines.svh.
`default_nettype none
`include "palette_tint_shade_blend_top_defines.svh"

module ptsb_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start,
  input wire logic        busy,
  input wire logic [7:0]  entry_index_i,
  input wire logic [5:0]  in_red_i,
  input wire logic [5:0]  in_green_i,
  input wire logic [5:0]  in_blue_i,
  input wire logic        out_valid_o,
  input wire logic [7:0]  out_index_o,
  input wire logic [5:0]  out_red_o,
  input wire logic [5:0]  out_green_o,
  input wire logic [5:0]  out_blue_o,
  input wire logic        was_blended_o,
  input wire logic        cfg_valid_i,
  input wire logic        cfg_ready_o,
  input wire logic [2:0]  cfg_index_i,
  input wire logic [17:0] cfg_data_i
);

  // Every request yields a result once it has passed the input register and the three steps.
  `PTSB_ASSERT(a_result_follows, (start && !busy) |-> ##4 out_valid_o, "result missing")

  // No result appears without a request that has passed the input register and the three steps.
  `PTSB_ASSERT(a_no_spurious, !(start && !busy) |-> ##4 !out_valid_o, "spurious result")

  // The entry index is echoed unchanged.
  `PTSB_ASSERT(a_index_echo, out_valid_o |-> (out_index_o == $past(entry_index_i, 4)),
    "index mismatch")

  // An entry that did not blend keeps its color.
  `PTSB_ASSERT(a_pass_through, (out_valid_o && !was_blended_o) |->
    ((out_red_o == $past(in_red_i, 4)) && (out_green_o == $past(in_green_i, 4)) &&
     (out_blue_o == $past(in_blue_i, 4))), "pass-through color changed")

endmodule

bind palette_tint_shade_blend_top ptsb_checker u_ptsb_checker (.*);

`default_nettype wire
